// ----- src/lws_pkg.sv -----
// shared types and constants for the latency window statistics block
// no dependencies
package lws_pkg;

	localparam int WINDOW_DEF = 128;
	localparam int DIV_W      = 48;
	localparam int DVS_W      = 64;
	localparam int RATE_W     = 24;

	localparam logic [DIV_W-1:0]  NS_Q8     = 48'd256000000000;
	localparam logic [RATE_W-1:0] RATE_MAX  = 24'hFFFFFF;
	// smallest 9*rate + instant whose tenth no longer fits the rate field
	localparam logic [DIV_W-1:0]  TEN_SAT   = 48'd167772160;
	// ceil(2^35 / 10), exact tenth for operands below 2^32
	localparam logic [31:0]       RECIP_TEN = 32'hCCCCCCCD;

	localparam logic [1:0] OP_MEAN = 2'd0;
	localparam logic [1:0] OP_INST = 2'd1;

	typedef struct packed {
		logic       load_in;
		logic       calc;
		logic       push;
		logic       div_go;
		logic [1:0] div_op;
		logic       take_mean;
		logic       sum_ten;
		logic       take_ten;
		logic       load_out;
	} lws_cmd_t;

	typedef struct packed {
		logic pub_zero;
		logic rate_upd;
		logic div_busy;
		logic scan_busy;
		logic out_free;
	} lws_stat_t;

endpackage

// ----- src/lws_div.sv -----
// iterative unsigned restoring divider, one quotient bit per cycle
// depends on lws_pkg
module lws_div import lws_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic [DIV_W-1:0] quotient,
	output logic             busy
);

	localparam int CW = $clog2(DIV_W + 1);

	logic [CW-1:0]    cnt_q;
	logic [DVS_W:0]   rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W:0]   rem_sh;
	logic             fit;

	assign rem_sh = {rem_q[DVS_W-1:0], quo_q[DIV_W-1]};
	assign fit    = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(DIV_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= fit ? rem_sh - {1'b0, dvs_q} : rem_sh;
			quo_q <= {quo_q[DIV_W-2:0], fit};
		end
	end

	assign quotient = quo_q;
	assign busy     = cnt_q != '0;

endmodule

// ----- src/lws_dp.sv -----
// datapath: delay ring, window sum, min/max scan, rate filter, output register
// depends on lws_pkg and lws_div
module lws_dp import lws_pkg::*; #(
	parameter int WINDOW = WINDOW_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lws_cmd_t            cmd,
	output lws_stat_t           stat,
	input  logic [63:0]         publish_ns,
	input  logic [63:0]         receive_ns,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                skipped,
	output logic signed [31:0]  delay_ns,
	output logic signed [31:0]  mean_delay_ns,
	output logic signed [31:0]  max_delay_ns,
	output logic signed [31:0]  min_delay_ns,
	output logic [7:0]          window_count,
	output logic [RATE_W-1:0]   rate_q8,
	output logic [31:0]         frames_seen
);

	localparam int HW    = $clog2(WINDOW);
	localparam int FW    = $clog2(WINDOW + 1);
	localparam int SUM_W = 32 + HW + 1;

	logic signed [31:0] ring [WINDOW];

	logic [63:0]          pub_q, rcv_q, last_q, diff_q;
	logic                 skip_q, rate_upd_q;
	logic signed [31:0]   delay_q, rd_q, mean_q, mx_q, mn_q;
	logic [HW-1:0]        head_q, sa_q, rd_addr;
	logic [FW-1:0]        fill_q;
	logic signed [SUM_W-1:0] sum_q;
	logic                 sum_neg_q;
	logic [RATE_W-1:0]    rate_q;
	logic [31:0]          frames_q;
	logic                 sact_q, rv_s1, first_q;
	logic [DIV_W-1:0]     tsum_q;

	logic signed [64:0]   diff65;
	logic signed [31:0]   sat_d;
	logic                 full;
	logic [DIV_W-1:0]     div_a, div_q;
	logic [DVS_W-1:0]     div_b;
	logic                 div_busy;
	logic [SUM_W-1:0]     sum_mag;
	logic                 out_free;
	logic [59:0]          ten_prod;

	// exact 65-bit difference, then clamp to int32
	assign diff65 = $signed({1'b0, rcv_q}) - $signed({1'b0, pub_q});
	always_comb begin
		if (!diff65[64] && (|diff65[63:31]))
			sat_d = 32'sh7FFFFFFF;
		else if (diff65[64] && !(&diff65[63:31]))
			sat_d = 32'sh80000000;
		else
			sat_d = diff65[31:0];
	end

	assign full    = fill_q == FW'(WINDOW);
	assign rd_addr = sact_q ? sa_q : head_q;
	assign sum_mag = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);

	// divide by ten as a reciprocal multiply, only needed below the saturation point
	assign ten_prod = {32'd0, tsum_q[27:0]} * {28'd0, RECIP_TEN};

	always_comb begin
		case (cmd.div_op)
			OP_MEAN: begin
				div_a = DIV_W'(sum_mag);
				div_b = DVS_W'(fill_q);
			end
			OP_INST: begin
				div_a = NS_Q8;
				div_b = diff_q;
			end
			default: begin
				div_a = '0;
				div_b = '0;
			end
		endcase
	end

	lws_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_go),
		.dividend (div_a),
		.divisor  (div_b),
		.quotient (div_q),
		.busy     (div_busy)
	);

	// ring memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (cmd.push)
			ring[head_q] <= delay_q;
		rd_q <= ring[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			fill_q     <= '0;
			sum_q      <= '0;
			last_q     <= '0;
			rate_q     <= '0;
			frames_q   <= '0;
			sact_q     <= 1'b0;
			rv_s1      <= 1'b0;
			first_q    <= 1'b0;
			out_valid  <= 1'b0;
			rate_upd_q <= 1'b0;
		end else begin
			if (cmd.calc) begin
				rate_upd_q <= (last_q != '0) && (rcv_q > last_q);
				last_q     <= rcv_q;
				frames_q   <= frames_q + 1'b1;
			end
			if (cmd.push) begin
				if (full)
					sum_q <= sum_q + SUM_W'(delay_q) - SUM_W'(rd_q);
				else begin
					sum_q  <= sum_q + SUM_W'(delay_q);
					fill_q <= fill_q + 1'b1;
				end
				head_q  <= (head_q == HW'(WINDOW - 1)) ? '0 : head_q + 1'b1;
				sact_q  <= 1'b1;
				first_q <= 1'b1;
			end else if (sact_q && (FW'(sa_q) == fill_q - 1'b1)) begin
				sact_q <= 1'b0;
			end
			rv_s1 <= sact_q;
			if (rv_s1)
				first_q <= 1'b0;
			if (cmd.take_ten)
				rate_q <= (tsum_q >= TEN_SAT) ? RATE_MAX : ten_prod[58:35];
			if (cmd.load_out)
				out_valid <= 1'b1;
			else if (!out_stall)
				out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			pub_q  <= publish_ns;
			rcv_q  <= receive_ns;
			skip_q <= publish_ns == '0;
		end
		if (cmd.calc) begin
			delay_q <= sat_d;
			diff_q  <= rcv_q - last_q;
		end
		if (cmd.push)
			sa_q <= '0;
		else if (sact_q)
			sa_q <= sa_q + 1'b1;
		if (cmd.div_go && cmd.div_op == OP_MEAN)
			sum_neg_q <= sum_q[SUM_W-1];
		if (cmd.take_mean)
			mean_q <= sum_neg_q ? -div_q[31:0] : div_q[31:0];
		if (cmd.sum_ten)
			tsum_q <= DIV_W'({rate_q, 3'b000}) + DIV_W'(rate_q) + div_q;
		if (rv_s1) begin
			if (first_q || rd_q > mx_q)
				mx_q <= rd_q;
			if (first_q || rd_q < mn_q)
				mn_q <= rd_q;
		end
		if (cmd.load_out) begin
			skipped       <= skip_q;
			delay_ns      <= skip_q ? '0 : delay_q;
			mean_delay_ns <= skip_q ? '0 : mean_q;
			max_delay_ns  <= skip_q ? '0 : mx_q;
			min_delay_ns  <= skip_q ? '0 : mn_q;
			window_count  <= 8'(fill_q);
			rate_q8       <= rate_q;
			frames_seen   <= frames_q;
		end
	end

	assign out_free = !out_valid || !out_stall;

	assign stat.pub_zero  = publish_ns == '0;
	assign stat.rate_upd  = rate_upd_q;
	assign stat.div_busy  = div_busy;
	assign stat.scan_busy = sact_q || rv_s1;
	assign stat.out_free  = out_free;

endmodule

// ----- src/lws_ctrl.sv -----
// controller: sequences load, push, the divider chain, scan and output
// depends on lws_pkg
module lws_ctrl import lws_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  lws_stat_t stat,
	output lws_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CALC  = 3'd1;
	localparam logic [2:0] S_PUSH  = 3'd2;
	localparam logic [2:0] S_MGO   = 3'd3;
	localparam logic [2:0] S_MEAN  = 3'd4;
	localparam logic [2:0] S_INST  = 3'd5;
	localparam logic [2:0] S_TEN   = 3'd6;
	localparam logic [2:0] S_FIN   = 3'd7;

	logic [2:0] state_q, state_d;
	logic       scanw_q, scanw_d;

	always_comb begin
		state_d = state_q;
		scanw_d = scanw_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = stat.pub_zero ? S_FIN : S_CALC;
				end
			end
			S_CALC: begin
				cmd.calc = 1'b1;
				state_d  = S_PUSH;
			end
			S_PUSH: begin
				cmd.push = 1'b1;
				state_d  = S_MGO;
			end
			S_MGO: begin
				cmd.div_go = 1'b1;
				cmd.div_op = OP_MEAN;
				state_d    = S_MEAN;
			end
			S_MEAN: begin
				if (!stat.div_busy) begin
					cmd.take_mean = 1'b1;
					if (stat.rate_upd) begin
						cmd.div_go = 1'b1;
						cmd.div_op = OP_INST;
						state_d    = S_INST;
					end else begin
						scanw_d = 1'b1;
						state_d = S_FIN;
					end
				end
			end
			S_INST: begin
				if (!stat.div_busy) begin
					cmd.sum_ten = 1'b1;
					state_d     = S_TEN;
				end
			end
			S_TEN: begin
				cmd.take_ten = 1'b1;
				scanw_d      = 1'b1;
				state_d      = S_FIN;
			end
			S_FIN: begin
				// wait for the scan to drain and the output slot to free up
				if (!(scanw_q && stat.scan_busy) && stat.out_free) begin
					cmd.load_out = 1'b1;
					scanw_d      = 1'b0;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			scanw_q <= 1'b0;
		end else begin
			state_q <= state_d;
			scanw_q <= scanw_d;
		end
	end

	assign in_stall = state_q != S_IDLE;

endmodule

// ----- src/latency_window_stats_top.sv -----
// Frame latency statistics over a sliding window of delays, with a smoothed
// frame rate. Input beat: publish_ns and receive_ns on in_valid/in_stall.
// Output beat: one result per input beat on out_valid/out_stall.
// A radix-2 divider computes the window mean, then, when the rate is
// updated, the instant rate, one bit per cycle each; the divide by ten is a
// reciprocal multiply. The min/max scan reads the ring memory one entry a
// cycle and runs alongside the divider. A valid frame takes the larger of
// the divider chain and the scan. A skipped frame (zero stamp) bypasses
// both and goes straight to the output register. One frame is in work at
// a time; in_stall is high from the accepting edge until the result is
// written to the output register. The output register holds a result
// while out_stall is high, and a new frame may be accepted meanwhile;
// the next result waits for it.
// Reset clears counters, sum, rate and last receive time; the ring memory
// is not cleared, only written entries are ever read.
// depends on lws_pkg, lws_ctrl, lws_dp
module latency_window_stats_top import lws_pkg::*; #(
	parameter int WINDOW = WINDOW_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [63:0]         publish_ns,
	input  logic [63:0]         receive_ns,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                skipped,
	output logic signed [31:0]  delay_ns,
	output logic signed [31:0]  mean_delay_ns,
	output logic signed [31:0]  max_delay_ns,
	output logic signed [31:0]  min_delay_ns,
	output logic [7:0]          window_count,
	output logic [RATE_W-1:0]   rate_q8,
	output logic [31:0]         frames_seen
);

	lws_cmd_t  cmd;
	lws_stat_t stat;

	lws_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	lws_dp #(.WINDOW(WINDOW)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.publish_ns    (publish_ns),
		.receive_ns    (receive_ns),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.skipped       (skipped),
		.delay_ns      (delay_ns),
		.mean_delay_ns (mean_delay_ns),
		.max_delay_ns  (max_delay_ns),
		.min_delay_ns  (min_delay_ns),
		.window_count  (window_count),
		.rate_q8       (rate_q8),
		.frames_seen   (frames_seen)
	);

endmodule

// ----- src/lws_chk.sv -----
// port-level checks for latency_window_stats_top, attached by bind
// depends on lws_pkg
module lws_chk import lws_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic               skipped,
	input logic signed [31:0] delay_ns,
	input logic signed [31:0] mean_delay_ns,
	input logic signed [31:0] max_delay_ns,
	input logic signed [31:0] min_delay_ns,
	input logic [31:0]        frames_seen
);

	// a stalled result beat stays up
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output beat dropped while stalled");

	// after an accepted beat the block is busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken back to back");

	a_skip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && skipped |-> delay_ns == 0 && mean_delay_ns == 0 &&
		max_delay_ns == 0 && min_delay_ns == 0)
		else $error("skipped beat carries nonzero stats");

	a_min_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !skipped |-> min_delay_ns <= max_delay_ns &&
		min_delay_ns <= mean_delay_ns && mean_delay_ns <= max_delay_ns)
		else $error("window stats out of order");

	a_frames: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !skipped |-> frames_seen != 0 || $past(frames_seen) != 0 ||
		!$past(out_valid))
		else $error("valid frame with zero frame count");

endmodule

bind latency_window_stats_top lws_chk u_lws_chk (.*);
